// ===== design/jss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the five-point stencil sweep block.
// No dependencies; the other design files except jss_ram refer to it by scoped names.
package jss_pkg;

    // grid and value geometry
    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 4096;
    localparam int VALUE_W     = 32;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COLS_CFG_W  = COL_W + 1;
    localparam int ROWS_CFG_W  = ROW_W + 1;
    localparam int SUM_W       = VALUE_W + 2;
    localparam int DIFF_W      = VALUE_W + 1;
    localparam int RESID_W     = 2 * VALUE_W;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = ROWS_CFG_W;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = CFG_INDEX_W'(1);

    // register limits
    localparam logic [ROWS_CFG_W-1:0] ROWS_MIN = ROWS_CFG_W'(3);
    localparam logic [ROWS_CFG_W-1:0] ROWS_MAX = ROWS_CFG_W'(MAX_ROWS);
    localparam logic [COLS_CFG_W-1:0] COLS_MIN = COLS_CFG_W'(3);
    localparam logic [COLS_CFG_W-1:0] COLS_MAX = COLS_CFG_W'(MAX_COLS);

    // one interior cell with its four neighbors and old value
    typedef struct packed {
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] left;
        logic signed [VALUE_W-1:0] right;
        logic signed [VALUE_W-1:0] top;
        logic signed [VALUE_W-1:0] bottom;
        logic signed [VALUE_W-1:0] center;
        logic                      last;
    } jss_stencil_t;

    // control from the line buffer front end to the update pipeline
    typedef struct packed {
        logic push;
        logic restart;
    } jss_front_ctrl_t;

endpackage

// ===== design/jss_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/jss_window.sv =====
`timescale 1ns / 1ps
// Front end: grid size registers, raster counters and the three line stores.
// Depends on jss_pkg and jss_ram; builds the neighbor set of each interior cell.
module jss_window (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [jss_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [jss_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 sample_accept,
    input  logic signed [jss_pkg::VALUE_W-1:0]   sample_value,
    output jss_pkg::jss_stencil_t                stencil,
    output jss_pkg::jss_front_ctrl_t             ctrl
);

    logic [jss_pkg::ROWS_CFG_W-1:0] grid_rows_reg, grid_rows_next;
    logic [jss_pkg::COLS_CFG_W-1:0] grid_cols_reg, grid_cols_next;
    logic [jss_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [jss_pkg::COL_W-1:0]      col_reg, col_next;
    logic [jss_pkg::VALUE_W-1:0]    left_reg, left_next;
    logic [jss_pkg::ROWS_CFG_W-1:0] rows_clamped;
    logic [jss_pkg::COLS_CFG_W-1:0] cols_clamped;
    logic [jss_pkg::COL_W-1:0]      right_addr;
    logic [jss_pkg::VALUE_W-1:0]    top_q, center_q, right_q;
    logic                           rows_write, cols_write;
    logic                           col_end, row_end, produce;

    assign rows_write = cfg_valid && (cfg_index == jss_pkg::REG_GRID_ROWS);
    assign cols_write = cfg_valid && (cfg_index == jss_pkg::REG_GRID_COLS);

    // clamp written sizes into the supported range
    always_comb
    begin
        rows_clamped = cfg_data[jss_pkg::ROWS_CFG_W-1:0];
        if (rows_clamped < jss_pkg::ROWS_MIN)
        begin
            rows_clamped = jss_pkg::ROWS_MIN;
        end
        else if (rows_clamped > jss_pkg::ROWS_MAX)
        begin
            rows_clamped = jss_pkg::ROWS_MAX;
        end
        cols_clamped = cfg_data[jss_pkg::COLS_CFG_W-1:0];
        if (cols_clamped < jss_pkg::COLS_MIN)
        begin
            cols_clamped = jss_pkg::COLS_MIN;
        end
        else if (cols_clamped > jss_pkg::COLS_MAX)
        begin
            cols_clamped = jss_pkg::COLS_MAX;
        end
    end

    // raster position decode
    assign col_end = (jss_pkg::COLS_CFG_W'(col_reg) == grid_cols_reg - jss_pkg::COLS_CFG_W'(1));
    assign row_end = (jss_pkg::ROWS_CFG_W'(row_reg) == grid_rows_reg - jss_pkg::ROWS_CFG_W'(1));
    assign produce = (row_reg >= jss_pkg::ROW_W'(2)) && (col_reg != '0)
                  && (jss_pkg::COLS_CFG_W'(col_reg) <= grid_cols_reg - jss_pkg::COLS_CFG_W'(2));

    // next register and counter values
    always_comb
    begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        left_next      = left_reg;
        if (rows_write || cols_write)
        begin
            if (rows_write)
            begin
                grid_rows_next = rows_clamped;
            end
            if (cols_write)
            begin
                grid_cols_next = cols_clamped;
            end
            row_next = '0;
            col_next = '0;
        end
        else if (sample_accept)
        begin
            left_next = center_q;
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + jss_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + jss_pkg::COL_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= jss_pkg::ROWS_MIN;
            grid_cols_reg <= jss_pkg::COLS_MIN;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else
        begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
        end
    end

    // left neighbor is the previous column's center
    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
    end

    // line stores, read ahead at the next raster column
    assign right_addr = col_next + jss_pkg::COL_W'(1);

    jss_ram #(
        .WIDTH (jss_pkg::VALUE_W),
        .DEPTH (jss_pkg::MAX_COLS)
    ) u_older_row (
        .clk     (clk),
        .wr_en   (sample_accept),
        .wr_addr (col_reg),
        .wr_data (center_q),
        .rd_addr (col_next),
        .rd_data (top_q)
    );

    jss_ram #(
        .WIDTH (jss_pkg::VALUE_W),
        .DEPTH (jss_pkg::MAX_COLS)
    ) u_prev_row_center (
        .clk     (clk),
        .wr_en   (sample_accept),
        .wr_addr (col_reg),
        .wr_data (sample_value),
        .rd_addr (col_next),
        .rd_data (center_q)
    );

    jss_ram #(
        .WIDTH (jss_pkg::VALUE_W),
        .DEPTH (jss_pkg::MAX_COLS)
    ) u_prev_row_right (
        .clk     (clk),
        .wr_en   (sample_accept),
        .wr_addr (col_reg),
        .wr_data (sample_value),
        .rd_addr (right_addr),
        .rd_data (right_q)
    );

    // neighbor set of the cell one row above the incoming sample
    always_comb
    begin
        stencil.row    = row_reg - jss_pkg::ROW_W'(1);
        stencil.col    = col_reg;
        stencil.left   = left_reg;
        stencil.right  = right_q;
        stencil.top    = top_q;
        stencil.bottom = sample_value;
        stencil.center = center_q;
        stencil.last   = row_end
                      && (jss_pkg::COLS_CFG_W'(col_reg) == grid_cols_reg - jss_pkg::COLS_CFG_W'(2));
        ctrl.push      = sample_accept && produce;
        ctrl.restart   = rows_write || cols_write;
    end

endmodule

// ===== design/jss_update.sv =====
`timescale 1ns / 1ps
// Update pipeline: neighbor average, squared change, saturating residual sum.
// Depends on jss_pkg; fed by jss_window, drives the result channel.
module jss_update (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  jss_pkg::jss_stencil_t                stencil,
    input  jss_pkg::jss_front_ctrl_t             ctrl,
    output logic                                 in_ready,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [jss_pkg::ROW_W-1:0]            center_row,
    output logic [jss_pkg::COL_W-1:0]            center_col,
    output logic signed [jss_pkg::VALUE_W-1:0]   new_value,
    output logic [jss_pkg::RESID_W-1:0]          residual_sum,
    output logic                                 last
);

    // stage 1: captured neighbor set
    logic                          s1_valid_reg;
    jss_pkg::jss_stencil_t         s1_reg;
    // stage 2: new value and change magnitude
    logic                          s2_valid_reg;
    logic [jss_pkg::ROW_W-1:0]     s2_row_reg;
    logic [jss_pkg::COL_W-1:0]     s2_col_reg;
    logic                          s2_last_reg;
    logic [jss_pkg::VALUE_W-1:0]   s2_new_reg;
    logic [jss_pkg::VALUE_W-1:0]   s2_mag_reg;
    // stage 3: squared change
    logic                          s3_valid_reg;
    logic [jss_pkg::ROW_W-1:0]     s3_row_reg;
    logic [jss_pkg::COL_W-1:0]     s3_col_reg;
    logic                          s3_last_reg;
    logic [jss_pkg::VALUE_W-1:0]   s3_new_reg;
    logic [jss_pkg::RESID_W-1:0]   s3_sq_reg;
    // output word and accumulator
    logic                          out_valid_reg;
    logic [jss_pkg::ROW_W-1:0]     out_row_reg;
    logic [jss_pkg::COL_W-1:0]     out_col_reg;
    logic                          out_last_reg;
    logic [jss_pkg::VALUE_W-1:0]   out_new_reg;
    logic [jss_pkg::RESID_W-1:0]   out_resid_reg;
    logic [jss_pkg::RESID_W-1:0]   acc_reg, acc_next;

    logic                          out_free, s3_free, s2_free, s1_free;
    logic [jss_pkg::SUM_W-1:0]     nbr_sum;
    logic [jss_pkg::VALUE_W-1:0]   avg;
    logic [jss_pkg::DIFF_W-1:0]    diff, diff_abs;
    logic [jss_pkg::RESID_W-1:0]   sq;
    logic [jss_pkg::RESID_W:0]     acc_wide;
    logic [jss_pkg::RESID_W-1:0]   acc_sat;

    // stall chain, bubbles collapse
    assign out_free = !out_valid_reg || result_ready;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;

    // floor average of the four neighbors and change against the old value
    always_comb
    begin
        nbr_sum = {{2{s1_reg.left[jss_pkg::VALUE_W-1]}}, s1_reg.left}
                + {{2{s1_reg.right[jss_pkg::VALUE_W-1]}}, s1_reg.right}
                + {{2{s1_reg.top[jss_pkg::VALUE_W-1]}}, s1_reg.top}
                + {{2{s1_reg.bottom[jss_pkg::VALUE_W-1]}}, s1_reg.bottom};
        avg      = nbr_sum[jss_pkg::SUM_W-1:2];
        diff     = {avg[jss_pkg::VALUE_W-1], avg}
                 - {s1_reg.center[jss_pkg::VALUE_W-1], s1_reg.center};
        diff_abs = diff[jss_pkg::DIFF_W-1] ? (~diff + jss_pkg::DIFF_W'(1)) : diff;
    end

    // square of the change magnitude
    assign sq = jss_pkg::RESID_W'(s2_mag_reg) * jss_pkg::RESID_W'(s2_mag_reg);

    // saturating running sum
    always_comb
    begin
        acc_wide = {1'b0, acc_reg} + {1'b0, s3_sq_reg};
        acc_sat  = acc_wide[jss_pkg::RESID_W] ? '1 : acc_wide[jss_pkg::RESID_W-1:0];
        acc_next = acc_reg;
        if (ctrl.restart)
        begin
            acc_next = '0;
        end
        else if (s3_valid_reg && out_free)
        begin
            acc_next = s3_last_reg ? '0 : acc_sat;
        end
    end

    // valid bits and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= ctrl.push;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            acc_reg <= acc_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_free && ctrl.push)
        begin
            s1_reg <= stencil;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_row_reg  <= s1_reg.row;
            s2_col_reg  <= s1_reg.col;
            s2_last_reg <= s1_reg.last;
            s2_new_reg  <= avg;
            s2_mag_reg  <= diff_abs[jss_pkg::VALUE_W-1:0];
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
            s3_last_reg <= s2_last_reg;
            s3_new_reg  <= s2_new_reg;
            s3_sq_reg   <= sq;
        end
        if (out_free && s3_valid_reg)
        begin
            out_row_reg   <= s3_row_reg;
            out_col_reg   <= s3_col_reg;
            out_last_reg  <= s3_last_reg;
            out_new_reg   <= s3_new_reg;
            out_resid_reg <= acc_sat;
        end
    end

    assign result_valid = out_valid_reg;
    assign center_row   = out_row_reg;
    assign center_col   = out_col_reg;
    assign new_value    = out_new_reg;
    assign residual_sum = out_resid_reg;
    assign last         = out_last_reg;

endmodule

// ===== design/jacobi_stencil_sweep.sv =====
`timescale 1ns / 1ps
// Top level of the streaming five-point stencil sweep.
// Depends on jss_pkg, jss_window (line stores, counters) and jss_update (math).
//
//   channel   direction   handshake                  payload
//   cfg       in          cfg_valid / cfg_ready      cfg_index, cfg_data
//   sample    in          sample_valid / sample_ready sample_value
//   result    out         result_valid / result_ready center_row, center_col,
//                                                     new_value, residual_sum, last
//
// One sample is taken every cycle while sample_ready is high; the line store reads run one
// column ahead of the raster counters, so consecutive samples never wait on memory.
// A result word is valid once the sample below its cell is taken and has passed the capture,
// average, square and accumulate registers in that order; boundary samples give no word.
// Reset clears the counters, valid bits and residual sum and sets a 3 by 3 grid;
// line store contents are undefined until a sweep writes them.
// A stalled result holds the pipeline; sample_ready drops only once every stage is full.
module jacobi_stencil_sweep (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jss_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [jss_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic signed [jss_pkg::VALUE_W-1:0]   sample_value,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [jss_pkg::ROW_W-1:0]            center_row,
    output logic [jss_pkg::COL_W-1:0]            center_col,
    output logic signed [jss_pkg::VALUE_W-1:0]   new_value,
    output logic [jss_pkg::RESID_W-1:0]          residual_sum,
    output logic                                 last
);

    jss_pkg::jss_stencil_t    stencil;
    jss_pkg::jss_front_ctrl_t ctrl;
    logic                     sample_accept;

    // configuration writes are always taken
    assign cfg_ready     = 1'b1;
    assign sample_accept = sample_valid && sample_ready;

    // line stores and raster position
    jss_window u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_accept (sample_accept),
        .sample_value  (sample_value),
        .stencil       (stencil),
        .ctrl          (ctrl)
    );

    // update arithmetic and result register
    jss_update u_update (
        .clk          (clk),
        .rst_n        (rst_n),
        .stencil      (stencil),
        .ctrl         (ctrl),
        .in_ready     (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .center_row   (center_row),
        .center_col   (center_col),
        .new_value    (new_value),
        .residual_sum (residual_sum),
        .last         (last)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for jacobi_stencil_sweep: streams grids in raster order and checks every
// updated cell against an in-bench copy of the stencil, line stores and residual sum.
// Depends on jss_pkg and the jacobi_stencil_sweep design files.
module tb_top;

    localparam int TIMEOUT_NS      = 4_000_000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int DRAIN_LIMIT     = 50_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 460;
    localparam int PRINT_LIMIT     = 40;

    localparam logic [jss_pkg::CFG_INDEX_W-1:0] REG_SPARE = jss_pkg::CFG_INDEX_W'(2);

    localparam logic signed [jss_pkg::VALUE_W-1:0] VAL_HIGH =
        {1'b0, {(jss_pkg::VALUE_W-1){1'b1}}};
    localparam logic signed [jss_pkg::VALUE_W-1:0] VAL_LOW  =
        {1'b1, {(jss_pkg::VALUE_W-1){1'b0}}};

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_CHOKED} sink_mode_t;

    // one updated interior cell as the block should report it
    typedef struct {
        logic [jss_pkg::ROW_W-1:0]          row;
        logic [jss_pkg::COL_W-1:0]          col;
        logic signed [jss_pkg::VALUE_W-1:0] value;
        logic [jss_pkg::RESID_W-1:0]        resid;
        logic                               tail;
    } cell_update_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [jss_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [jss_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                               sample_valid;
    logic                               sample_ready;
    logic signed [jss_pkg::VALUE_W-1:0] sample_value;
    logic                               result_valid;
    logic                               result_ready;
    logic [jss_pkg::ROW_W-1:0]          center_row;
    logic [jss_pkg::COL_W-1:0]          center_col;
    logic signed [jss_pkg::VALUE_W-1:0] new_value;
    logic [jss_pkg::RESID_W-1:0]        residual_sum;
    logic                               last;

    // stencil state mirrored in the bench
    logic signed [jss_pkg::VALUE_W-1:0] upper_line [jss_pkg::MAX_COLS];
    logic signed [jss_pkg::VALUE_W-1:0] middle_line [jss_pkg::MAX_COLS];
    int                                 raster_row;
    int                                 raster_col;
    logic [jss_pkg::RESID_W-1:0]        change_energy;
    int                                 cfg_rows;
    int                                 cfg_cols;

    cell_update_t cell_updates_due[$];
    int           mismatch_count = 0;

    // sender and receiver control
    bit offering     = 1'b0;
    bit steady_feed  = 1'b0;
    bit hold_off_req = 1'b0;
    int burst_left   = 0;

    jacobi_stencil_sweep i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_value (sample_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .center_row   (center_row),
        .center_col   (center_col),
        .new_value    (new_value),
        .residual_sum (residual_sum),
        .last         (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("ERROR %0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // counters and residual sum go back to the top of a sweep
    function automatic void restart_sweep();
        raster_row    = 0;
        raster_col    = 0;
        change_energy = '0;
    endfunction

    function automatic void reset_stencil();
        foreach (upper_line[i])
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        cfg_rows = int'(jss_pkg::ROWS_MIN);
        cfg_cols = int'(jss_pkg::COLS_MIN);
        restart_sweep();
    endfunction

    // register write with clamping; the column register uses only its low bits
    function automatic void load_register(input logic [jss_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [jss_pkg::CFG_DATA_W-1:0] data);
        logic [jss_pkg::COLS_CFG_W-1:0] col_bits;
        col_bits = data[jss_pkg::COLS_CFG_W-1:0];
        if (idx == jss_pkg::REG_GRID_ROWS)
        begin
            if (data < jss_pkg::ROWS_MIN)
                cfg_rows = int'(jss_pkg::ROWS_MIN);
            else if (data > jss_pkg::ROWS_MAX)
                cfg_rows = int'(jss_pkg::ROWS_MAX);
            else
                cfg_rows = int'(data);
            restart_sweep();
        end
        else if (idx == jss_pkg::REG_GRID_COLS)
        begin
            if (col_bits < jss_pkg::COLS_MIN)
                cfg_cols = int'(jss_pkg::COLS_MIN);
            else if (col_bits > jss_pkg::COLS_MAX)
                cfg_cols = int'(jss_pkg::COLS_MAX);
            else
                cfg_cols = int'(col_bits);
            restart_sweep();
        end
    endfunction

    // take one raster sample; queue the cell update it completes, if any
    function automatic void relax_sample(input logic signed [jss_pkg::VALUE_W-1:0] bottom_v);
        logic signed [jss_pkg::VALUE_W-1:0] top_v;
        logic signed [jss_pkg::VALUE_W-1:0] old_v;
        logic signed [jss_pkg::VALUE_W-1:0] left_v;
        logic signed [jss_pkg::VALUE_W-1:0] right_v;
        longint                             sum4;
        longint                             avg;
        longint                             delta;
        logic [63:0]                        mag;
        logic [jss_pkg::RESID_W:0]          acc;
        cell_update_t                       cu;

        top_v = upper_line[raster_col];
        old_v = middle_line[raster_col];
        upper_line[raster_col]  = old_v;
        middle_line[raster_col] = bottom_v;

        if (raster_row >= 2 && raster_col >= 1 && raster_col + 2 <= cfg_cols)
        begin
            // left neighbor already moved up one sample ago
            left_v  = upper_line[raster_col - 1];
            right_v = middle_line[raster_col + 1];
            sum4  = longint'(left_v) + longint'(right_v) + longint'(top_v) + longint'(bottom_v);
            avg   = sum4 >>> 2;
            delta = avg - longint'(old_v);
            mag   = (delta < 0) ? 64'(-delta) : 64'(delta);
            acc   = {1'b0, change_energy} + {1'b0, mag * mag};
            change_energy = acc[jss_pkg::RESID_W] ? '1 : acc[jss_pkg::RESID_W-1:0];

            cu.row   = jss_pkg::ROW_W'(raster_row - 1);
            cu.col   = jss_pkg::COL_W'(raster_col);
            cu.value = avg[jss_pkg::VALUE_W-1:0];
            cu.resid = change_energy;
            cu.tail  = (raster_row + 1 == cfg_rows) && (raster_col + 2 == cfg_cols);
            cell_updates_due.push_back(cu);
        end

        raster_col++;
        if (raster_col >= cfg_cols)
        begin
            raster_col = 0;
            raster_row++;
            if (raster_row >= cfg_rows)
            begin
                restart_sweep();
            end
        end
    endfunction

    // compare one accepted result word with the oldest expected update
    task automatic check_result();
        cell_update_t want;
        if (cell_updates_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result row %0d col %0d", center_row, center_col));
            return;
        end
        want = cell_updates_due.pop_front();
        if (center_row !== want.row)
            report_mismatch($sformatf("center_row got %0d want %0d", center_row, want.row));
        if (center_col !== want.col)
            report_mismatch($sformatf("center_col got %0d want %0d", center_col, want.col));
        if (new_value !== want.value)
            report_mismatch($sformatf("cell %0d,%0d new_value got %h want %h",
                                      want.row, want.col, new_value, want.value));
        if (residual_sum !== want.resid)
            report_mismatch($sformatf("cell %0d,%0d residual_sum got %h want %h",
                                      want.row, want.col, residual_sum, want.resid));
        if (last !== want.tail)
            report_mismatch($sformatf("cell %0d,%0d last got %b want %b",
                                      want.row, want.col, last, want.tail));
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_ready === 1'b1)
        begin
            check_result();
        end
    end

    // result receiver: random stall modes, plus a long hold-off on request
    initial
    begin : result_sink
        int         hold_left;
        int         mode_left;
        sink_mode_t mode;
        hold_left = 0;
        mode_left = 0;
        mode = SINK_OPEN;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 96);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_OPEN:   result_ready <= 1'b1;
                    SINK_COIN:   result_ready <= ($urandom_range(0, 1) == 0);
                    SINK_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                    default:     result_ready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    // send one sample word, opening a random gap between bursts
    task automatic send_sample(input logic signed [jss_pkg::VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            if (steady_feed || $urandom_range(0, 2) == 0)
                gap = 0;
            else if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(10, 30);
            else
                gap = $urandom_range(1, 6);
            if (gap != 0 && offering)
            begin
                sample_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample_value <= v;
        offering = 1'b1;
        @(posedge clk);
        while (sample_ready !== 1'b1) @(posedge clk);
        relax_sample(v);
    endtask

    function automatic logic signed [jss_pkg::VALUE_W-1:0] pick_value();
        logic signed [jss_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = VAL_HIGH;
            1: v = VAL_LOW;
            2:
            begin
                v = $urandom_range(0, 511);
                v = v - 256;
            end
            3: v = ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic stream_samples(input int count);
        repeat (count) send_sample(pick_value());
    endtask

    // drop valid, let every expected word arrive, then let the pipeline empty
    task automatic wait_idle();
        if (offering)
        begin
            sample_valid <= 1'b0;
            offering = 1'b0;
        end
        while (cell_updates_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [jss_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [jss_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        cfg_valid <= 1'b0;
        load_register(idx, data);
    endtask

    task automatic set_grid(input logic [jss_pkg::CFG_DATA_W-1:0] rows_data,
                            input logic [jss_pkg::CFG_DATA_W-1:0] cols_data);
        wait_idle();
        write_reg(jss_pkg::REG_GRID_ROWS, rows_data);
        wait_idle();
        write_reg(jss_pkg::REG_GRID_COLS, cols_data);
    endtask

    // reset grid of 3 by 3: floor toward minus infinity and extreme corners
    task automatic test_reset_grid();
        logic signed [jss_pkg::VALUE_W-1:0] grid [9];
        grid = '{VAL_LOW, 32'sd1, VAL_HIGH,
                 -32'sd2, 32'sh12345678, 32'sd1,
                 VAL_HIGH, -32'sd1, VAL_LOW};
        foreach (grid[i]) send_sample(grid[i]);
    endtask

    // two full-scale changes in one sweep push the residual sum to saturation
    task automatic test_residual_saturation();
        logic signed [jss_pkg::VALUE_W-1:0] grid [12];
        grid = '{32'sd0, VAL_HIGH, VAL_LOW, -32'sd1,
                 VAL_HIGH, VAL_LOW, VAL_HIGH, VAL_LOW,
                 32'sd1, VAL_HIGH, VAL_LOW, 32'sd0};
        set_grid(3, 4);
        foreach (grid[i]) send_sample(grid[i]);
    endtask

    // out of range register values, masked column bits, spare index written mid-sweep
    task automatic test_register_clamp();
        set_grid(0, 2);
        stream_samples(9);
        set_grid('1, 13'h1805);
        stream_samples(100);
        wait_idle();
        write_reg(REG_SPARE, '1);
        stream_samples(50);
    endtask

    // clamped widest setting, the top rows of the tallest grid, exact maximum width
    task automatic test_extreme_grids();
        set_grid(3, 13'h07FF);
        stream_samples(jss_pkg::MAX_COLS / 4);
        set_grid(jss_pkg::CFG_DATA_W'(jss_pkg::MAX_ROWS), 3);
        stream_samples(3 * 64);
        set_grid(3, jss_pkg::CFG_DATA_W'(jss_pkg::MAX_COLS));
        stream_samples(16);
    endtask

    // random grid sizes, back to back sweeps, some cut short by the next setup
    task automatic test_random_grids();
        int sent;
        int h;
        int w;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                h = $urandom_range(3, 5);
                w = $urandom_range(17, 160);
            end
            else
            begin
                h = $urandom_range(3, 9);
                w = $urandom_range(3, 16);
            end
            set_grid(jss_pkg::CFG_DATA_W'(h), jss_pkg::CFG_DATA_W'(w));
            n = h * w * $urandom_range(1, 3);
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, n);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            stream_samples(n);
            sent += n;
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        set_grid(6, 12);
        steady_feed = 1'b1;
        hold_off_req = 1'b1;
        stream_samples(6 * 12 * 2);
        steady_feed = 1'b0;
    endtask

    initial
    begin
        int drain;
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        sample_valid <= 1'b0;
        sample_value <= '0;
        reset_stencil();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_grid();
        test_residual_saturation();
        test_register_clamp();
        test_extreme_grids();
        test_random_grids();
        test_output_backpressure();

        // drain outstanding words, then let the pipeline settle
        if (offering)
        begin
            sample_valid <= 1'b0;
            offering = 1'b0;
        end
        drain = 0;
        while (cell_updates_due.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (cell_updates_due.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      cell_updates_due.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("jacobi_stencil_sweep regression: pass");
        end
        else
        begin
            $display("jacobi_stencil_sweep regression: fail");
        end
        $finish;
    end

    // hard stop if the run hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("jacobi_stencil_sweep regression: fail");
        $finish;
    end

endmodule
